@@ rtl/coc_pkg.sv @@
// Shared types and constants of the cascade origin cache.
package coc_pkg;

   // Fraction bits of the signed Q16.16 coordinates
   localparam int FracBits = 16;

   // 0.05 as a Q0.16 factor on the cached extent
   localparam logic [12:0] ExtentScale = 13'd3277;

   // 1e-4 expressed in Q16.16 LSBs
   localparam logic [47:0] ThrBias = 48'd7;

   // One table entry: origin and extent of a cascade
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] e;
   } entry_type;

   // Status of the distance checker toward the sequencer
   typedef struct packed {
      logic done;
      logic hit;
   } dist_status_type;

endpackage

@@ rtl/coc_table.sv @@
// Entry memory of the cascade origin cache: one write port, one registered read port.
module coc_table #(
   parameter int DEPTH  = 4,
   parameter int ADDR_W = 2
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  coc_pkg::entry_type     wr_data,
   input  logic [ADDR_W-1:0]      rd_addr,
   output coc_pkg::entry_type     rd_data
);

   coc_pkg::entry_type entry_mem [DEPTH];
   coc_pkg::entry_type rd_data_ff;

   // Write on request, read every cycle into a register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/coc_dist.sv @@
// Hit test of one cascade entry over a shared 32x32 multiplier.
module coc_dist (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  coc_pkg::entry_type        cached,
   input  coc_pkg::entry_type        fresh,
   output coc_pkg::dist_status_type  status
);

   typedef enum logic [7:0] {
      D_IDLE = 8'b0000_0001,
      D_PROD = 8'b0000_0010,
      D_THR  = 8'b0000_0100,
      D_TT   = 8'b0000_1000,
      D_SX   = 8'b0001_0000,
      D_SY   = 8'b0010_0000,
      D_SZ   = 8'b0100_0000,
      D_SUM  = 8'b1000_0000
   } dist_state_type;

   dist_state_type     state_ff, state_in;
   logic signed [31:0] ce_ff, ce_in;
   logic [32:0]        de_ff, de_in;
   logic [32:0]        dx_ff, dx_in;
   logic [32:0]        dy_ff, dy_in;
   logic [32:0]        dz_ff, dz_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [26:0]        t_ff, t_in;
   logic [55:0]        lim_ff, lim_in;
   logic [55:0]        acc_ff, acc_in;
   logic               done_ff, done_in;
   logic               hit_ff, hit_in;

   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [63:0] mul_p;
   logic signed [47:0] thr;
   logic [47:0]        thr_u;
   logic               thr_fail;
   logic [55:0]        sum;

   // Exact magnitude of the difference of two signed words
   function automatic logic [32:0] mag_diff(input logic [31:0] a, input logic [31:0] b);
      logic signed [32:0] d;
      d = $signed({a[31], a}) - $signed({b[31], b});
      return d[32] ? 33'(-d) : 33'(d);
   endfunction

   // Select the operands of the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         D_PROD: begin
            mul_a = ce_ff;
            mul_b = $signed({19'd0, coc_pkg::ExtentScale});
         end
         D_TT: begin
            mul_a = $signed({5'd0, t_ff});
            mul_b = $signed({5'd0, t_ff});
         end
         D_SX: begin
            mul_a = $signed({5'd0, dx_ff[26:0]});
            mul_b = $signed({5'd0, dx_ff[26:0]});
         end
         D_SY: begin
            mul_a = $signed({5'd0, dy_ff[26:0]});
            mul_b = $signed({5'd0, dy_ff[26:0]});
         end
         D_SZ: begin
            mul_a = $signed({5'd0, dz_ff[26:0]});
            mul_b = $signed({5'd0, dz_ff[26:0]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Threshold: floor of the scaled extent plus the bias
   assign thr      = 48'(prod_ff >>> coc_pkg::FracBits) + $signed(coc_pkg::ThrBias);
   assign thr_u    = thr;
   assign thr_fail = thr[47] || ({15'd0, de_ff} > thr_u) || ({15'd0, dx_ff} > thr_u)
                     || ({15'd0, dy_ff} > thr_u) || ({15'd0, dz_ff} > thr_u);
   assign sum      = acc_ff + prod_ff[55:0];

   // Sequence the threshold, the squares and the final compare
   always_comb begin
      state_in = state_ff;
      ce_in    = ce_ff;
      de_in    = de_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      dz_in    = dz_ff;
      prod_in  = prod_ff;
      t_in     = t_ff;
      lim_in   = lim_ff;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      hit_in   = hit_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               ce_in    = $signed(cached.e);
               de_in    = mag_diff(fresh.e, cached.e);
               dx_in    = mag_diff(fresh.x, cached.x);
               dy_in    = mag_diff(fresh.y, cached.y);
               dz_in    = mag_diff(fresh.z, cached.z);
               state_in = D_PROD;
            end
         end
         D_PROD: begin
            prod_in  = mul_p;
            state_in = D_THR;
         end
         D_THR: begin
            if (thr_fail) begin
               done_in  = 1'b1;
               hit_in   = 1'b0;
               state_in = D_IDLE;
            end else begin
               t_in     = thr_u[26:0];
               state_in = D_TT;
            end
         end
         D_TT: begin
            prod_in  = mul_p;
            state_in = D_SX;
         end
         D_SX: begin
            lim_in   = prod_ff[55:0];
            prod_in  = mul_p;
            state_in = D_SY;
         end
         D_SY: begin
            acc_in   = prod_ff[55:0];
            prod_in  = mul_p;
            state_in = D_SZ;
         end
         D_SZ: begin
            acc_in   = sum;
            prod_in  = mul_p;
            state_in = D_SUM;
         end
         D_SUM: begin
            done_in  = 1'b1;
            hit_in   = (sum <= lim_ff);
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      ce_ff   <= ce_in;
      de_ff   <= de_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dz_ff   <= dz_in;
      prod_ff <= prod_in;
      t_ff    <= t_in;
      lim_ff  <= lim_in;
      acc_ff  <= acc_in;
      hit_ff  <= hit_in;
   end

   assign status.done = done_ff;
   assign status.hit  = hit_ff;

endmodule

@@ rtl/cascade_origin_cache.sv @@
// Top level of the cascade origin cache: sequencer, counters, valid bits and result register.
//
//   port group   direction  handshake            contents
//   req_*        in         req_valid/req_stall  kind, cascade index, origin, extent
//   rsp_*        out        rsp_valid/rsp_stall  rerender, frame and counters, valid entries
//   csr_*        in         csr_write_en         active cascade count (3 bits)
//
// One item at a time. A clear, an out-of-range update or an update of an empty
// entry goes from the read state straight to the result state; an update that runs
// the distance test waits in the check state, ending early if the threshold fails,
// while the shared multiplier forms the threshold and then the four squares one per cycle.
// Reset is synchronous and leaves all entries invalid; no clearing pass is needed.
// A stalled result holds in the output register; the next item waits only if the
// register is still full when its own result is ready.
module cascade_origin_cache #(
   parameter int CASCADES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_cascade_index,
   input  logic [31:0] req_origin_x,
   input  logic [31:0] req_origin_y,
   input  logic [31:0] req_origin_z,
   input  logic [31:0] req_extent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_rerender,
   output logic [31:0] rsp_frame_count,
   output logic [31:0] rsp_last_rendered_frame,
   output logic [31:0] rsp_hit_count,
   output logic [31:0] rsp_miss_count,
   output logic [31:0] rsp_rendered_count,
   output logic [2:0]  rsp_valid_entries,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_write_data
);

   localparam int IW = (CASCADES > 1) ? $clog2(CASCADES) : 1;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_READ   = 4'b0010,
      S_CHECK  = 4'b0100,
      S_RESULT = 4'b1000
   } seq_state_type;

   seq_state_type      state_ff, state_in;
   logic [2:0]         active_ff, active_in;
   logic [CASCADES-1:0] valid_ff, valid_in;
   logic [31:0]        frame_ff, frame_in;
   logic [31:0]        hits_ff, hits_in;
   logic [31:0]        misses_ff, misses_in;
   logic [31:0]        renders_ff, renders_in;
   logic               kind_ff, kind_in;
   logic [7:0]         idx_ff, idx_in;
   coc_pkg::entry_type fresh_ff, fresh_in;
   logic               miss_ff, miss_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rer_ff, rer_in;
   logic [31:0]        out_frame_ff, out_frame_in;
   logic [31:0]        lrf_ff, lrf_in;
   logic [31:0]        out_hits_ff, out_hits_in;
   logic [31:0]        out_misses_ff, out_misses_in;
   logic [31:0]        out_renders_ff, out_renders_in;
   logic [2:0]         out_valid_ff, out_valid_in;

   logic                    accept;
   logic                    slot_free;
   logic                    commit;
   logic [2:0]              in_use;
   logic                    in_range;
   logic                    dist_start;
   logic                    wr_en;
   logic [2:0]              valid_cnt;
   coc_pkg::entry_type      cached;
   coc_pkg::dist_status_type dist_status;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == S_RESULT) && slot_free;
   assign wr_en     = commit && !kind_ff && in_range && miss_ff;

   // Clamp the active count to 1..CASCADES
   always_comb begin
      if (active_ff == 3'd0) begin
         in_use = 3'd1;
      end else if (int'(active_ff) > CASCADES) begin
         in_use = 3'(CASCADES);
      end else begin
         in_use = active_ff;
      end
   end

   assign in_range = ({5'd0, in_use} > idx_ff);

   coc_table #(
      .DEPTH  (CASCADES),
      .ADDR_W (IW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff[IW-1:0]),
      .wr_data (fresh_ff),
      .rd_addr (req_cascade_index[IW-1:0]),
      .rd_data (cached)
   );

   coc_dist u_dist (
      .clock  (clock),
      .reset  (reset),
      .start  (dist_start),
      .cached (cached),
      .fresh  (fresh_ff),
      .status (dist_status)
   );

   // Count valid entries among the active cascades after this item
   always_comb begin
      valid_cnt = 3'd0;
      for (int i = 0; i < CASCADES; i++) begin
         if (valid_in[i] && (i < int'(in_use))) begin
            valid_cnt = valid_cnt + 3'd1;
         end
      end
   end

   // Sequencer, statistics and result register
   always_comb begin
      state_in       = state_ff;
      active_in      = csr_write_en ? csr_write_data : active_ff;
      valid_in       = valid_ff;
      frame_in       = frame_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      renders_in     = renders_ff;
      kind_in        = kind_ff;
      idx_in         = idx_ff;
      fresh_in       = fresh_ff;
      miss_in        = miss_ff;
      dist_start     = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rer_in         = rer_ff;
      out_frame_in   = out_frame_ff;
      lrf_in         = lrf_ff;
      out_hits_in    = out_hits_ff;
      out_misses_in  = out_misses_ff;
      out_renders_in = out_renders_ff;
      out_valid_in   = out_valid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in    = req_kind;
               idx_in     = req_cascade_index;
               fresh_in.x = req_origin_x;
               fresh_in.y = req_origin_y;
               fresh_in.z = req_origin_z;
               fresh_in.e = req_extent;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            // Entry data is now out of the memory; decide the short cases
            miss_in  = 1'b1;
            state_in = S_RESULT;
            if (kind_ff) begin
               miss_in = 1'b0;
            end else if (in_range) begin
               if (valid_ff[idx_ff[IW-1:0]]) begin
                  dist_start = 1'b1;
                  state_in   = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (dist_status.done) begin
               miss_in  = !dist_status.hit;
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (slot_free) begin
               if (kind_ff) begin
                  hits_in    = '0;
                  misses_in  = '0;
                  renders_in = '0;
               end else begin
                  frame_in = frame_ff + 32'd1;
                  if (miss_ff) begin
                     misses_in  = misses_ff + 32'd1;
                     renders_in = renders_ff + 32'd1;
                  end else begin
                     hits_in = hits_ff + 32'd1;
                  end
                  if (in_range && miss_ff) begin
                     valid_in[idx_ff[IW-1:0]] = 1'b1;
                  end
               end
               rsp_valid_in   = 1'b1;
               rer_in         = !kind_ff && miss_ff;
               out_frame_in   = frame_in;
               lrf_in         = (!kind_ff && in_range) ? frame_in : 32'd0;
               out_hits_in    = hits_in;
               out_misses_in  = misses_in;
               out_renders_in = renders_in;
               out_valid_in   = valid_cnt;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 3'd4;
         valid_ff     <= '0;
         frame_ff     <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         renders_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         valid_ff     <= valid_in;
         frame_ff     <= frame_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         renders_ff   <= renders_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      idx_ff         <= idx_in;
      fresh_ff       <= fresh_in;
      miss_ff        <= miss_in;
      rer_ff         <= rer_in;
      out_frame_ff   <= out_frame_in;
      lrf_ff         <= lrf_in;
      out_hits_ff    <= out_hits_in;
      out_misses_ff  <= out_misses_in;
      out_renders_ff <= out_renders_in;
      out_valid_ff   <= out_valid_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_rerender            = rer_ff;
   assign rsp_frame_count         = out_frame_ff;
   assign rsp_last_rendered_frame = lrf_ff;
   assign rsp_hit_count           = out_hits_ff;
   assign rsp_miss_count          = out_misses_ff;
   assign rsp_rendered_count      = out_renders_ff;
   assign rsp_valid_entries       = out_valid_ff;

   // An accepted item always goes to the entry read first
   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_READ)
      else $error("accepted item did not enter the read state");

   // The checker reports only while the sequencer waits for it
   a_done_in_check: assert property (@(posedge clock) disable iff (reset)
      dist_status.done |-> state_ff == S_CHECK)
      else $error("distance result outside the check state");

   // An update advances the frame counter by one
   a_frame_step: assert property (@(posedge clock) disable iff (reset)
      commit && !kind_ff |=> frame_ff == $past(frame_ff) + 32'd1)
      else $error("frame counter did not advance");

   // A nonzero stored frame is the current frame
   a_lrf_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (lrf_ff != 32'd0) |-> lrf_ff == out_frame_ff)
      else $error("last rendered frame differs from frame count");

   // A stored miss marks its entry valid
   a_valid_set: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(idx_ff[IW-1:0])])
      else $error("written entry not marked valid");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the cascade origin cache: directed table, random traffic, checker.
`timescale 1ns / 1ps

module tb;

   localparam int NumCascades     = 4;
   localparam longint ThrScale    = 3277;   // 0.05 in Q0.16
   localparam longint ThrBias     = 7;      // 1e-4 in Q16.16 LSBs
   localparam int QuietLimit      = 2000;   // cycles without any transfer
   localparam int LongHold        = 400;    // receiver hold-off under pressure
   localparam int DrainSlack      = 12;     // longer than the slowest item
   localparam int MaxShown        = 10;

   typedef enum logic {
      KIND_UPDATE = 1'b0,
      KIND_CLEAR  = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    cascade_index;
      logic [31:0]   origin_x;
      logic [31:0]   origin_y;
      logic [31:0]   origin_z;
      logic [31:0]   extent;
   } cascade_request_type;

   typedef struct packed {
      logic        rerender;
      logic [31:0] frame_count;
      logic [31:0] last_rendered_frame;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
      logic [31:0] rendered_count;
      logic [2:0]  valid_entries;
   } cache_report_type;

   typedef struct {
      cascade_request_type req;
      bit                  typed;
      cache_report_type    want;
   } directed_row_type;

   typedef struct {
      logic [2:0] active;
      int         idle_pct;
      int         stall_pct;
      int         items;
      bit         long_hold;
      bit         drain_pauses;
   } traffic_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [7:0]  req_cascade_index = '0;
   logic [31:0] req_origin_x = '0;
   logic [31:0] req_origin_y = '0;
   logic [31:0] req_origin_z = '0;
   logic [31:0] req_extent = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_rerender;
   logic [31:0] rsp_frame_count;
   logic [31:0] rsp_last_rendered_frame;
   logic [31:0] rsp_hit_count;
   logic [31:0] rsp_miss_count;
   logic [31:0] rsp_rendered_count;
   logic [2:0]  rsp_valid_entries;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_write_data = '0;

   // Shadow copy of the cache table, counters and active-count register
   logic [31:0] shadow_x [NumCascades];
   logic [31:0] shadow_y [NumCascades];
   logic [31:0] shadow_z [NumCascades];
   logic [31:0] shadow_ext [NumCascades];
   logic [31:0] shadow_frame [NumCascades];
   bit          shadow_valid [NumCascades];
   logic [31:0] frame_ctr = '0;
   logic [31:0] hit_ctr = '0;
   logic [31:0] miss_ctr = '0;
   logic [31:0] render_ctr = '0;
   logic [2:0]  active_reg = 3'd4;

   cache_report_type  reports_due[$];
   directed_row_type  directed_rows[24];
   traffic_phase_type phases[7];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_off_left = 0;
   int mismatch_count = 0;
   int reports_checked = 0;
   int requests_sent = 0;
   int hits_seen = 0;
   int misses_seen = 0;
   int clears_seen = 0;
   int settings_tried = 0;
   int quiet_cycles = 0;

   cascade_origin_cache #(
      .CASCADES(NumCascades)
   ) dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_kind                (req_kind),
      .req_cascade_index       (req_cascade_index),
      .req_origin_x            (req_origin_x),
      .req_origin_y            (req_origin_y),
      .req_origin_z            (req_origin_z),
      .req_extent              (req_extent),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_rerender            (rsp_rerender),
      .rsp_frame_count         (rsp_frame_count),
      .rsp_last_rendered_frame (rsp_last_rendered_frame),
      .rsp_hit_count           (rsp_hit_count),
      .rsp_miss_count          (rsp_miss_count),
      .rsp_rendered_count      (rsp_rendered_count),
      .rsp_valid_entries       (rsp_valid_entries),
      .csr_write_en            (csr_write_en),
      .csr_write_data          (csr_write_data)
   );

   always #1 clock = ~clock;

   // Clamp the register to the cascades that exist
   function automatic int unsigned cascades_in_use();
      if (active_reg == 3'd0) return 1;
      if (active_reg > NumCascades) return NumCascades;
      return active_reg;
   endfunction

   // Hit radius from a cached extent: floor(extent * 0.05) + 1e-4, may be negative
   function automatic longint hit_radius(logic [31:0] ext);
      longint scaled;
      scaled = longint'($signed(ext)) * ThrScale;
      return (scaled >>> 16) + ThrBias;
   endfunction

   function automatic longint gap(logic [31:0] a, logic [31:0] b);
      longint d;
      d = longint'($signed(a)) - longint'($signed(b));
      return (d < 0) ? -d : d;
   endfunction

   // Apply one accepted request to the shadow cache and return its report
   function automatic cache_report_type cache_lookup_report(cascade_request_type r);
      cache_report_type rep;
      int unsigned      live;
      int unsigned      slot;
      longint           radius;
      longint           dx;
      longint           dy;
      longint           dz;
      bit               hit;
      rep = '0;
      live = cascades_in_use();
      if (r.kind == KIND_CLEAR) begin
         hit_ctr = '0;
         miss_ctr = '0;
         render_ctr = '0;
         clears_seen++;
      end else begin
         frame_ctr = frame_ctr + 32'd1;
         if (r.cascade_index >= live) begin
            miss_ctr = miss_ctr + 32'd1;
            render_ctr = render_ctr + 32'd1;
            rep.rerender = 1'b1;
            misses_seen++;
         end else begin
            slot = r.cascade_index;
            hit = 1'b0;
            if (shadow_valid[slot]) begin
               radius = hit_radius(shadow_ext[slot]);
               dx = gap(r.origin_x, shadow_x[slot]);
               dy = gap(r.origin_y, shadow_y[slot]);
               dz = gap(r.origin_z, shadow_z[slot]);
               hit = radius >= 0 && gap(r.extent, shadow_ext[slot]) <= radius
                     && dx <= radius && dy <= radius && dz <= radius
                     && dx * dx + dy * dy + dz * dz <= radius * radius;
            end
            if (hit) begin
               hit_ctr = hit_ctr + 32'd1;
               hits_seen++;
            end else begin
               miss_ctr = miss_ctr + 32'd1;
               render_ctr = render_ctr + 32'd1;
               rep.rerender = 1'b1;
               misses_seen++;
               shadow_x[slot] = r.origin_x;
               shadow_y[slot] = r.origin_y;
               shadow_z[slot] = r.origin_z;
               shadow_ext[slot] = r.extent;
               shadow_valid[slot] = 1'b1;
            end
            shadow_frame[slot] = frame_ctr;
            rep.last_rendered_frame = frame_ctr;
         end
      end
      rep.frame_count = frame_ctr;
      rep.hit_count = hit_ctr;
      rep.miss_count = miss_ctr;
      rep.rendered_count = render_ctr;
      for (int i = 0; i < live; i++)
         if (shadow_valid[i]) rep.valid_entries = rep.valid_entries + 3'd1;
      return rep;
   endfunction

   function automatic logic [31:0] nudge(logic [31:0] base, int unsigned span);
      return base + 32'($urandom_range(0, 2 * span)) - 32'(span);
   endfunction

   // Mostly small moves around a cached entry, the rest clears, out-of-range indices, fresh entries and noise
   function automatic cascade_request_type random_request();
      cascade_request_type r;
      int unsigned         pick;
      int unsigned         slot;
      int unsigned         span;
      longint              radius;
      r.kind = KIND_UPDATE;
      r.cascade_index = 8'($urandom_range(0, NumCascades - 1));
      r.origin_x = $urandom();
      r.origin_y = $urandom();
      r.origin_z = $urandom();
      r.extent = $urandom();
      slot = r.cascade_index;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         r.kind = KIND_CLEAR;
      end else if (pick < 10) begin
         r.cascade_index = 8'($urandom());
      end else if (pick < 28 || !shadow_valid[slot]) begin
         r.extent = $urandom_range(0, 32'h0040_0000);
         if ($urandom_range(0, 7) == 0) r.extent = -r.extent;
         if ($urandom_range(0, 1) == 1) begin
            r.origin_x = 32'($signed(16'($urandom())));
            r.origin_y = 32'($signed(16'($urandom())));
            r.origin_z = 32'($signed(16'($urandom())));
         end
      end else if (pick < 95) begin
         radius = hit_radius(shadow_ext[slot]);
         if (radius < 0) radius = 8;
         if ($urandom_range(0, 1) == 1) span = int'(radius / 2 + 1);
         else span = int'(radius + radius / 8 + 2);
         r.origin_x = nudge(shadow_x[slot], span);
         r.origin_y = nudge(shadow_y[slot], span);
         r.origin_z = nudge(shadow_z[slot], span);
         r.extent = nudge(shadow_ext[slot], span);
      end
      return r;
   endfunction

   // Offer one request, hold it until transfer, then queue its report
   task automatic offer_request(input cascade_request_type r, input bit typed,
                                input cache_report_type want);
      cache_report_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= r.kind;
      req_cascade_index <= r.cascade_index;
      req_origin_x <= r.origin_x;
      req_origin_y <= r.origin_y;
      req_origin_z <= r.origin_z;
      req_extent <= r.extent;
      do @(posedge clock); while (req_stall);
      predicted = cache_lookup_report(r);
      reports_due.push_back(typed ? want : predicted);
      requests_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every queued report has come back
   task automatic wait_all_reports();
      req_valid <= 1'b0;
      do @(negedge clock); while (reports_due.size() != 0);
   endtask

   task automatic write_active_count(input logic [2:0] value);
      wait_all_reports();
      repeat (DrainSlack) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      active_reg = value;
      settings_tried++;
   endtask

   task automatic log_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MaxShown)
         $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
   endtask

   // Receiver: random stall, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // Check each result transfer against the oldest queued report
   always @(posedge clock) begin
      cache_report_type seen;
      cache_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_rerender, rsp_frame_count, rsp_last_rendered_frame, rsp_hit_count,
                  rsp_miss_count, rsp_rendered_count, rsp_valid_entries};
         if (reports_due.size() == 0) begin
            log_mismatch("result with nothing queued, frame_count", '0, seen.frame_count);
         end else begin
            want = reports_due.pop_front();
            reports_checked++;
            if (seen.rerender !== want.rerender)
               log_mismatch("rerender", 32'(want.rerender), 32'(seen.rerender));
            if (seen.frame_count !== want.frame_count)
               log_mismatch("frame_count", want.frame_count, seen.frame_count);
            if (seen.last_rendered_frame !== want.last_rendered_frame)
               log_mismatch("last_rendered_frame", want.last_rendered_frame,
                            seen.last_rendered_frame);
            if (seen.hit_count !== want.hit_count)
               log_mismatch("hit_count", want.hit_count, seen.hit_count);
            if (seen.miss_count !== want.miss_count)
               log_mismatch("miss_count", want.miss_count, seen.miss_count);
            if (seen.rendered_count !== want.rendered_count)
               log_mismatch("rendered_count", want.rendered_count, seen.rendered_count);
            if (seen.valid_entries !== want.valid_entries)
               log_mismatch("valid_entries", 32'(want.valid_entries),
                            32'(seen.valid_entries));
         end
      end
   end

   // Watchdog: end the run after too long without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("timeout: no transfer for %0d cycles, %0d reports outstanding",
                  QuietLimit, reports_due.size());
         $display("FAIL cascade_origin_cache");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NumCascades; i++) begin
         shadow_x[i] = '0;
         shadow_y[i] = '0;
         shadow_z[i] = '0;
         shadow_ext[i] = '0;
         shadow_frame[i] = '0;
         shadow_valid[i] = 1'b0;
      end

      // kind, index, x, y, z, extent; typed report where it is obvious
      directed_rows = '{
         // first update after reset misses and fills entry 0
         '{'{KIND_UPDATE, 8'd0, 32'h0, 32'h0, 32'h0, 32'h0001_0000}, 1'b1,
           '{1'b1, 32'd1, 32'd1, 32'd0, 32'd1, 32'd1, 3'd1}},
         // clear keeps the frame and the table
         '{'{KIND_CLEAR, 8'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
           '{1'b0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 3'd1}},
         // index out of range: miss without touching the table
         '{'{KIND_UPDATE, 8'd255, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
             32'h8000_0000}, 1'b1,
           '{1'b1, 32'd2, 32'd0, 32'd0, 32'd1, 32'd1, 3'd1}},
         '{'{KIND_UPDATE, 8'd4, 32'h0, 32'h0, 32'h0, 32'h0001_0000}, 1'b1,
           '{1'b1, 32'd3, 32'd0, 32'd0, 32'd2, 32'd2, 3'd1}},
         // exact repeat, then distance right at and just past the radius
         '{'{KIND_UPDATE, 8'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000}, 1'b0, '0},
         '{'{KIND_UPDATE, 8'd0, 32'd3284, 32'd0, 32'd0, 32'h0001_0000}, 1'b0, '0},
         '{'{KIND_UPDATE, 8'd0, 32'd3285, 32'd0, 32'd0, 32'h0001_0000}, 1'b0, '0},
         // squared sum just inside, then just outside
         '{'{KIND_UPDATE, 8'd0, 32'd3285, 32'd2322, 32'd2322, 32'h0001_0000}, 1'b0, '0},
         '{'{KIND_UPDATE, 8'd0, 32'd3285, 32'd2323, 32'd2322, 32'h0001_0000}, 1'b0, '0},
         // extent change at and past the radius
         '{'{KIND_UPDATE, 8'd0, 32'd3285, 32'd2323, 32'd2322, 32'h0001_0CD4}, 1'b0, '0},
         '{'{KIND_UPDATE, 8'd0, 32'd3285, 32'd2323, 32'd2322, 32'h0001_0CD5}, 1'b0, '0},
         // extremes of origin and extent; negative radius always misses
         '{'{KIND_UPDATE, 8'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF}, 1'b0, '0},
         '{'{KIND_UPDATE, 8'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000}, 1'b0, '0},
         '{'{KIND_UPDATE, 8'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000}, 1'b0, '0},
         // zero extent: radius is the bias alone
         '{'{KIND_UPDATE, 8'd2, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
         '{'{KIND_UPDATE, 8'd2, 32'd7, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
         '{'{KIND_UPDATE, 8'd2, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFF9}, 1'b0, '0},
         // small negative extent rounds the radius down
         '{'{KIND_UPDATE, 8'd3, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b0, '0},
         '{'{KIND_UPDATE, 8'd3, 32'h0, 32'h0, 32'hFFFF_FFFA, 32'hFFFF_FFFF}, 1'b0, '0},
         // radius of exactly zero
         '{'{KIND_UPDATE, 8'd3, 32'h0, 32'h0, 32'h0, 32'hFFFF_FF75}, 1'b0, '0},
         '{'{KIND_UPDATE, 8'd3, 32'h0, 32'h0, 32'h0, 32'hFFFF_FF75}, 1'b0, '0},
         '{'{KIND_UPDATE, 8'd3, 32'h0, 32'd1, 32'h0, 32'hFFFF_FF75}, 1'b0, '0},
         '{'{KIND_CLEAR, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF}, 1'b0, '0},
         '{'{KIND_UPDATE, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF}, 1'b0, '0}
      };

      // active count, sender idle %, receiver stall %, items, hold-off, drain pauses
      phases = '{
         '{3'd4, 0,  0,  300, 1'b0, 1'b0},
         '{3'd1, 73, 0,  200, 1'b0, 1'b0},
         '{3'd7, 0,  73, 300, 1'b0, 1'b0},
         '{3'd0, 30, 30, 150, 1'b0, 1'b0},
         '{3'd2, 30, 30, 250, 1'b1, 1'b0},
         '{3'd3, 0,  0,  200, 1'b0, 1'b1},
         '{3'd4, 30, 30, 200, 1'b1, 1'b1}
      };

      // Hold reset, then release it at a falling edge
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_active_count(3'd4);
      foreach (directed_rows[i])
         offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      foreach (phases[p]) begin
         write_active_count(phases[p].active);
         sender_idle_pct = phases[p].idle_pct;
         receiver_stall_pct = phases[p].stall_pct;
         for (int n = 0; n < phases[p].items; n++) begin
            if (phases[p].long_hold && n == phases[p].items / 3)
               hold_off_left = LongHold;
            if (phases[p].drain_pauses && n % 40 == 39)
               wait_all_reports();
            offer_request(random_request(), 1'b0, '0);
         end
      end

      // Drain, then let the block settle before the verdict
      wait_all_reports();
      repeat (DrainSlack) @(negedge clock);
      $display("covered %0d requests (%0d directed) over %0d active-count writes",
               requests_sent, $size(directed_rows), settings_tried);
      $display("outcomes: %0d hits, %0d misses, %0d clears; %0d reports checked",
               hits_seen, misses_seen, clears_seen, reports_checked);
      if (mismatch_count == 0 && reports_due.size() == 0) begin
         $display("PASS cascade_origin_cache");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAIL cascade_origin_cache");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/coc_pkg.sv
rtl/coc_table.sv
rtl/coc_dist.sv
rtl/cascade_origin_cache.sv
dv/tb.sv
